[sv/mcpf_pkg.sv]
// ----------------------------------------------------------------------------
// mcpf_pkg
// Shared types and constants for the motor command packet framer: command
// kinds, codes, header reset values and the descriptor passed front to back.
// ----------------------------------------------------------------------------
package mcpf_pkg;

   // command kinds on the request side
   typedef enum logic [1:0] {
      KIND_RUN       = 2'd0,
      KIND_FREE_STOP = 2'd1,
      KIND_BRAKE     = 2'd2,
      KIND_POWER_ON  = 2'd3
   } kind_type;

   // register indexes on the csr port
   localparam logic CSR_RX_HEADER = 1'b0;
   localparam logic CSR_TX_HEADER = 1'b1;

   localparam logic [7:0] RX_HEADER_RESET = 8'd183;
   localparam logic [7:0] TX_HEADER_RESET = 8'd184;

   // command codes, payload lengths and fixed payloads
   localparam logic [7:0] CODE_RUN         = 8'd130;
   localparam logic [7:0] CODE_FREE_STOP   = 8'd5;
   localparam logic [7:0] CODE_BRAKE       = 8'd6;
   localparam logic [7:0] CODE_POWER_ON    = 8'd10;
   localparam logic [7:0] LEN_RUN          = 8'd2;
   localparam logic [7:0] LEN_FIXED        = 8'd1;
   localparam logic [7:0] PAYLOAD_STOP     = 8'd1;
   localparam logic [7:0] PAYLOAD_POWER_ON = 8'd5;

   // byte positions within a packet
   localparam int unsigned IDX_W = 3;
   localparam logic [IDX_W-1:0] POS_RX_HEADER = 3'd0;
   localparam logic [IDX_W-1:0] POS_TX_HEADER = 3'd1;
   localparam logic [IDX_W-1:0] POS_MOTOR_ID  = 3'd2;
   localparam logic [IDX_W-1:0] POS_CODE      = 3'd3;
   localparam logic [IDX_W-1:0] POS_LENGTH    = 3'd4;
   localparam logic [IDX_W-1:0] POS_PAYLOAD0  = 3'd5;
   localparam logic [IDX_W-1:0] POS_PAYLOAD1  = 3'd6;
   localparam logic [IDX_W-1:0] POS_LAST_RUN  = 3'd7;
   localparam logic [IDX_W-1:0] POS_LAST_FIX  = 3'd6;

   // command queue depth default
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // classified command, front to back
   typedef struct packed {
      logic       is_run;
      logic [7:0] motor_id;
      logic [7:0] code;
      logic [7:0] length;
      logic [7:0] payload0;
      logic [7:0] payload1;
   } desc_type;

   // header register values seen by the back end
   typedef struct packed {
      logic [7:0] rx;
      logic [7:0] tx;
   } hdr_type;

   // queue status towards front and back
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

[sv/mcpf_front.sv]
// ----------------------------------------------------------------------------
// mcpf_front
// Accepts request beats and classifies them into packet descriptors: code,
// payload length and payload bytes, ready for the command queue.
// ----------------------------------------------------------------------------
module mcpf_front
   import mcpf_pkg::*;
(
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_motor_id,
   input  logic signed [15:0] req_speed_value,
   input  qstat_type          qstat,
   output logic               push,
   output desc_type           push_desc
);

   // take a beat whenever the queue has room
   assign req_ready = !qstat.full;
   assign push      = req_valid && !qstat.full;

   // command table lookup
   always_comb begin
      push_desc          = '0;
      push_desc.motor_id = req_motor_id;
      case (kind_type'(req_type))
         KIND_RUN: begin
            push_desc.is_run   = 1'b1;
            push_desc.code     = CODE_RUN;
            push_desc.length   = LEN_RUN;
            push_desc.payload0 = req_speed_value[7:0];
            push_desc.payload1 = req_speed_value[15:8];
         end
         KIND_FREE_STOP: begin
            push_desc.code     = CODE_FREE_STOP;
            push_desc.length   = LEN_FIXED;
            push_desc.payload0 = PAYLOAD_STOP;
         end
         KIND_BRAKE: begin
            push_desc.code     = CODE_BRAKE;
            push_desc.length   = LEN_FIXED;
            push_desc.payload0 = PAYLOAD_STOP;
         end
         default: begin
            push_desc.code     = CODE_POWER_ON;
            push_desc.length   = LEN_FIXED;
            push_desc.payload0 = PAYLOAD_POWER_ON;
         end
      endcase
   end

endmodule

[sv/mcpf_queue.sv]
// ----------------------------------------------------------------------------
// mcpf_queue
// Short first-in first-out queue of packet descriptors between the front
// and the back, so each side stalls on its own.
// ----------------------------------------------------------------------------
module mcpf_queue
   import mcpf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  desc_type  push_desc,
   input  logic      pop,
   output desc_type  pop_desc,
   output qstat_type qstat
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   desc_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == CNT_FULL);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign pop_desc    = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

[sv/mcpf_back.sv]
// ----------------------------------------------------------------------------
// mcpf_back
// Serialises a descriptor into packet bytes, one per cycle unless rsp stalls,
// with a running sum for the checksum byte; drives the response register.
// ----------------------------------------------------------------------------
module mcpf_back
   import mcpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  hdr_type    hdr,
   input  qstat_type  qstat,
   input  desc_type   pop_desc,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_packet_byte,
   output logic       rsp_last_byte
);

   logic             active_ff,  active_in;
   desc_type         desc_ff,    desc_in;
   logic [IDX_W-1:0] idx_ff,     idx_in;
   logic [7:0]       sum_ff,     sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff,  rsp_byte_in;
   logic             rsp_last_ff,  rsp_last_in;
   logic             advance, is_last;
   logic [7:0]       cur_byte;
   logic [IDX_W-1:0] last_pos;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packet_byte = rsp_byte_ff;
   assign rsp_last_byte   = rsp_last_ff;

   // emit a beat whenever the output register is free or being drained
   assign advance  = active_ff && (!rsp_valid_ff || rsp_ready);
   assign last_pos = desc_ff.is_run ? POS_LAST_RUN : POS_LAST_FIX;
   assign is_last  = (idx_ff == last_pos);
   assign pop      = (!active_ff || (advance && is_last)) && !qstat.empty;

   // byte at the current position
   always_comb begin
      case (idx_ff)
         POS_RX_HEADER: cur_byte = hdr.rx;
         POS_TX_HEADER: cur_byte = hdr.tx;
         POS_MOTOR_ID:  cur_byte = desc_ff.motor_id;
         POS_CODE:      cur_byte = desc_ff.code;
         POS_LENGTH:    cur_byte = desc_ff.length;
         POS_PAYLOAD0:  cur_byte = desc_ff.payload0;
         POS_PAYLOAD1:  cur_byte = desc_ff.is_run ? desc_ff.payload1 : 8'(-sum_ff);
         default:       cur_byte = 8'(-sum_ff);
      endcase
   end

   // sequencer and output register next state
   always_comb begin
      active_in    = active_ff;
      desc_in      = desc_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = is_last;
         idx_in       = idx_ff + 1'b1;
         sum_in       = sum_ff + cur_byte;
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         active_in = 1'b1;
         desc_in   = pop_desc;
         idx_in    = '0;
         sum_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

[sv/motor_command_packet_framer.sv]
// ----------------------------------------------------------------------------
// motor_command_packet_framer
// Frames motor-driver commands into serial packets: two header bytes, id,
// code, length, payload and a two's complement checksum, one byte a beat.
// ----------------------------------------------------------------------------
//  channel | ports                                   | beat
//  --------+-----------------------------------------+----------------------
//  req     | req_valid/ready, type, motor_id, speed  | one command
//  rsp     | rsp_valid/ready, packet_byte, last_byte | one packet byte
//  csr     | csr_write_enable, csr_index, data       | one header register
//
//  A run packet has 8 bytes, the others 7: one byte per cycle from the
//  back-end serialiser unless rsp stalls. Packets follow with no gap.
//  The command queue holds QUEUE_DEPTH commands, so requests keep being
//  taken while rsp is stalled until the queue fills.
//  Synchronous reset empties the queue and the output register and loads
//  the header reset values.
// ----------------------------------------------------------------------------
module motor_command_packet_framer
   import mcpf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_motor_id,
   input  logic signed [15:0] req_speed_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_packet_byte,
   output logic               rsp_last_byte,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [7:0]         csr_write_data
);

   hdr_type   hdr_ff, hdr_in;
   qstat_type qstat;
   desc_type  push_desc, pop_desc;
   logic      push, pop;

   // header registers
   always_comb begin
      hdr_in = hdr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RX_HEADER: hdr_in.rx = csr_write_data;
            CSR_TX_HEADER: hdr_in.tx = csr_write_data;
            default:       hdr_in = hdr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff.rx <= RX_HEADER_RESET;
         hdr_ff.tx <= TX_HEADER_RESET;
      end else begin
         hdr_ff <= hdr_in;
      end
   end

   mcpf_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_motor_id    (req_motor_id),
      .req_speed_value (req_speed_value),
      .qstat           (qstat),
      .push            (push),
      .push_desc       (push_desc)
   );

   mcpf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .qstat     (qstat)
   );

   mcpf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .hdr             (hdr_ff),
      .qstat           (qstat),
      .pop_desc        (pop_desc),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

[sv/mcpf_checker.sv]
// ----------------------------------------------------------------------------
// mcpf_checker
// Port-level checks on the response stream: hold under stall, packet
// length, length byte and zero-sum checksum. Bound to the top level.
// ----------------------------------------------------------------------------
module mcpf_checker
   import mcpf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_packet_byte,
   input logic       rsp_last_byte
);

   logic [IDX_W-1:0] pos_ff;
   logic [7:0]       sum_ff;
   logic             beat;

   assign beat = rsp_valid && rsp_ready;

   // track position and running sum within the current packet
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else if (beat) begin
         pos_ff <= rsp_last_byte ? '0 : pos_ff + 1'b1;
         sum_ff <= rsp_last_byte ? '0 : sum_ff + rsp_packet_byte;
      end
   end

   // a stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_packet_byte) && $stable(rsp_last_byte))
      else $error("rsp beat changed while stalled");

   // packets are seven or eight bytes
   a_length: assert property (@(posedge clock) disable iff (reset)
      beat && rsp_last_byte |-> (pos_ff == POS_LAST_FIX) || (pos_ff == POS_LAST_RUN))
      else $error("packet ended at wrong position");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      beat && (pos_ff == POS_LAST_RUN) |-> rsp_last_byte)
      else $error("packet longer than eight bytes");

   // length byte is one of the two payload lengths
   a_len_byte: assert property (@(posedge clock) disable iff (reset)
      beat && (pos_ff == POS_LENGTH) |->
         (rsp_packet_byte == LEN_RUN) || (rsp_packet_byte == LEN_FIXED))
      else $error("bad payload length byte");

   // all bytes of a packet sum to zero
   a_checksum: assert property (@(posedge clock) disable iff (reset)
      beat && rsp_last_byte |-> (8'(sum_ff + rsp_packet_byte) == 8'd0))
      else $error("checksum mismatch");

endmodule

bind motor_command_packet_framer mcpf_checker u_mcpf_checker (.*);

[tb/mcpf_packet_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpf_packet_checker
// Watches the command, packet and csr ports of the framer. Every command beat
// taken is framed into the bytes it should produce, and each packet byte beat
// is compared against the oldest of them. It reports the mismatch count and
// the number of bytes still owed.
// ----------------------------------------------------------------------------
module mcpf_packet_checker
   import mcpf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_motor_id,
   input  logic signed [15:0] req_speed_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_packet_byte,
   input  logic               rsp_last_byte,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [7:0]         csr_write_data,
   output int unsigned        mismatch_count,
   output int unsigned        pending_bytes
);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } framed_byte_type;

   framed_byte_type expected_bytes[$];
   logic [7:0]      rx_header = RX_HEADER_RESET;
   logic [7:0]      tx_header = TX_HEADER_RESET;

   // frame one command and queue its bytes in transmit order
   function automatic void frame_command(input kind_type kind, input logic [7:0] id,
                                         input logic [15:0] speed);
      logic [7:0]      body [8];
      int unsigned     count;
      logic [7:0]      sum;
      framed_byte_type entry;
      body[0] = rx_header;
      body[1] = tx_header;
      body[2] = id;
      count   = 6;
      case (kind)
         KIND_RUN: begin
            body[3] = CODE_RUN;
            body[4] = LEN_RUN;
            body[5] = speed[7:0];
            body[6] = speed[15:8];
            count   = 7;
         end
         KIND_FREE_STOP: begin
            body[3] = CODE_FREE_STOP;
            body[4] = LEN_FIXED;
            body[5] = PAYLOAD_STOP;
         end
         KIND_BRAKE: begin
            body[3] = CODE_BRAKE;
            body[4] = LEN_FIXED;
            body[5] = PAYLOAD_STOP;
         end
         default: begin
            body[3] = CODE_POWER_ON;
            body[4] = LEN_FIXED;
            body[5] = PAYLOAD_POWER_ON;
         end
      endcase
      // checksum makes the whole packet sum to zero
      sum = 8'd0;
      for (int i = 0; i < count; i++) sum = sum + body[i];
      body[count] = 8'd0 - sum;
      count++;
      for (int i = 0; i < count; i++) begin
         entry.data = body[i];
         entry.last = (i == count - 1);
         expected_bytes.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      framed_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         rx_header = RX_HEADER_RESET;
         tx_header = TX_HEADER_RESET;
         mismatch_count <= 0;
      end else begin
         // packet byte beat against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected packet byte %02h last %0b, expected nothing",
                        $time, rsp_packet_byte, rsp_last_byte);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_packet_byte !== want.data || rsp_last_byte !== want.last) begin
                  $display({"%0t: packet mismatch, expected byte %02h last %0b,",
                            " got byte %02h last %0b"},
                           $time, want.data, want.last, rsp_packet_byte, rsp_last_byte);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         // command beat
         if (req_valid && req_ready)
            frame_command(kind_type'(req_type), req_motor_id, req_speed_value);
         // header writes
         if (csr_write_enable) begin
            if (csr_index == CSR_RX_HEADER)
               rx_header = csr_write_data;
            else
               tx_header = csr_write_data;
         end
      end
      pending_bytes <= expected_bytes.size();
   end

endmodule

[tb/motor_command_packet_framer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_packet_framer_tb
// Drives commands and header writes into the framer: a directed sweep of
// field extremes and all command kinds, then random commands under three
// stall patterns on both channels. The checker beside the block predicts
// each packet and counts mismatches; this top gives the verdict.
// ----------------------------------------------------------------------------
module motor_command_packet_framer_tb
   import mcpf_pkg::*;
();

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned ITEMS_PER_PHASE = 52;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type = KIND_RUN;
   logic [7:0]         req_motor_id = 8'd0;
   logic signed [15:0] req_speed_value = 16'sd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_packet_byte;
   logic               rsp_last_byte;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = CSR_RX_HEADER;
   logic [7:0]         csr_write_data = 8'd0;

   int unsigned        mismatch_count;
   int unsigned        pending_bytes;
   int unsigned        send_idle_pct = 6;
   int unsigned        recv_idle_pct = 68;
   int unsigned        quiet_cycles = 0;

   motor_command_packet_framer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_motor_id     (req_motor_id),
      .req_speed_value  (req_speed_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_packet_byte  (rsp_packet_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   mcpf_packet_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_motor_id     (req_motor_id),
      .req_speed_value  (req_speed_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_packet_byte  (rsp_packet_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_bytes    (pending_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // packet receiver stalls at random
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // watchdog: too long with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one command beat; called and returns at a falling edge
   task automatic send_command(input kind_type kind, input logic [7:0] id,
                               input logic [15:0] speed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_motor_id    <= id;
      req_speed_value <= speed;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random_command();
      send_command(kind_type'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
   endtask

   // hold off until every packet byte owed has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_bytes != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   // write both header registers, block idle
   task automatic program_headers(input logic [7:0] rx, input logic [7:0] tx);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_RX_HEADER;
      csr_write_data   <= rx;
      @(negedge clock);
      csr_index        <= CSR_TX_HEADER;
      csr_write_data   <= tx;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset headers, speed extremes, every kind, speed ignored
      send_command(KIND_RUN,       8'd0,   16'h0000);
      send_command(KIND_RUN,       8'd255, 16'h7FFF);
      send_command(KIND_RUN,       8'd1,   16'h8000);
      send_command(KIND_RUN,       8'd128, 16'hFFFF);
      send_command(KIND_RUN,       8'h5A,  16'h00FF);
      send_command(KIND_FREE_STOP, 8'd0,   16'hFFFF);
      send_command(KIND_BRAKE,     8'd255, 16'h7FFF);
      send_command(KIND_POWER_ON,  8'h33,  16'h8000);
      send_command(KIND_FREE_STOP, 8'hA5,  16'h0000);
      wait_drained();

      // header extremes
      program_headers(8'd0, 8'd255);
      send_command(KIND_RUN,       8'd255, 16'hFFFF);
      send_command(KIND_POWER_ON,  8'd255, 16'h0000);
      send_command(KIND_BRAKE,     8'd0,   16'h1234);
      wait_drained();
      program_headers(8'd255, 8'd0);
      send_command(KIND_RUN,       8'd0,   16'h0000);
      send_command(KIND_FREE_STOP, 8'd127, 16'h8000);
      send_command(KIND_POWER_ON,  8'd128, 16'h1234);
      wait_drained();

      // random: sender rarely idle, receiver mostly stalled
      program_headers(8'($urandom), 8'($urandom));
      send_idle_pct = 6;
      recv_idle_pct = 68;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
         send_random_command();
         if (i == ITEMS_PER_PHASE / 2)
            wait_drained();
      end
      wait_drained();

      // random: sender mostly idle, receiver rarely stalled
      program_headers(8'($urandom), 8'($urandom));
      send_idle_pct = 68;
      recv_idle_pct = 6;
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
         send_random_command();
      wait_drained();

      // random: back to back at full rate, headers back to reset values
      program_headers(RX_HEADER_RESET, TX_HEADER_RESET);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
         send_random_command();
      wait_drained();

      if (mismatch_count == 0 && pending_bytes == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
